// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the run-length bitmap blitter.
// No dependencies; simulation gets the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define RBB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rbb assertion failed");
// Clocked check that also holds during reset.
`define RBB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("rbb assertion failed");
`else
`define RBB_ASSERT(label, clk, rst, prop)
`define RBB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/rbb_pkg.sv =====
// Package for the run-length bitmap blitter: request codes, decode phases,
// fixed constants and the command/status structs between control and datapath.
`timescale 1ns / 1ps
`default_nettype none
package rbb_pkg;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PATTERN = 2'd1;
   localparam logic [1:0] PHASE_COUNT   = 2'd2;

   // CSR register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_X     = 2'd2;
   localparam logic [1:0] CSR_ORIGIN_Y     = 2'd3;

   localparam logic [7:0] ESCAPE_BYTE = 8'h76;
   localparam int         FLIP_BASE   = 64;

   // column walk: 8-bit start column plus up to 255 * 8 pixels
   localparam int COL_W = 12;
   localparam int PIX_W = 11;

   typedef struct packed {
      logic capture;
      logic start_image;
      logic set_escape;
      logic set_pattern;
      logic run_load;
      logic run_from_pending;
      logic draw;
      logic run_end;
      logic read_mem;
      logic clear;
      logic rsp_load;
   } rbb_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] phase;
      logic       is_escape;
      logic       done;
      logic       run_more;
      logic       clear_last;
   } rbb_stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/rbb_req_if.sv =====
// Request channel of the blitter: valid/ready handshake plus request payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rbb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] code_byte;
   logic [9:0] read_index;

   modport source (output valid, output req_type, output code_byte, output read_index,
                   input ready);
   modport sink   (input valid, input req_type, input code_byte, input read_index,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rbb_rsp_if.sv =====
// Response channel of the blitter: valid/ready handshake plus result payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface rbb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       image_done;

   modport source (output valid, output read_data, output image_done, input ready);
   modport sink   (input valid, input read_data, input image_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rbb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rbb_datapath.sv =====
// Blitter datapath: config registers, decoder state, pixel walk, framebuffer RAM
// and the response register. Depends on rbb_pkg, rbb_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rbb_datapath #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS    = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rbb_pkg::rbb_cmd_type cmd,
   output rbb_pkg::rbb_stat_type    stat,
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [7:0]          csr_wdata,
   input  wire logic [1:0]          req_type,
   input  wire logic [7:0]          code_byte,
   input  wire logic [9:0]          read_index,
   output logic      [7:0]          read_data,
   output logic                     image_done
);
   import rbb_pkg::*;

   localparam int DEPTH = SCREEN_COLUMNS * ((SCREEN_ROWS + 7) / 8);
   localparam int AW    = $clog2(DEPTH);

   // configuration
   logic [7:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;
   logic [6:0] origin_x_ff, origin_x_in;
   logic [5:0] origin_y_ff, origin_y_in;

   // decoder state
   logic [1:0] phase_ff, phase_in;
   logic [7:0] pattern_ff, pattern_in;
   logic [7:0] column_ff, column_in;
   logic [6:0] row_ff, row_in;

   // latched request
   logic [1:0] req_type_ff, req_type_in;
   logic [7:0] code_ff, code_in;
   logic [9:0] index_ff, index_in;

   // run walk
   logic [7:0]       run_pattern_ff, run_pattern_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [PIX_W-1:0] total_ff, total_in;
   logic [6:0]       y_ff, y_in;
   logic             yok_ff, yok_in;

   // write stage of the read-modify-write
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [2:0]    wr_bit_ff, wr_bit_in;
   logic          wr_on_ff, wr_on_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    read_data_ff, read_data_in;
   logic          done_ff, done_in;

   logic          done_now;
   logic [7:0]    y_sum;
   logic          y_ok_now;
   logic [COL_W:0] x_pos;
   logic          pix_vis;
   logic [AW-1:0] pix_addr;
   logic          index_ok;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;
   logic [7:0]    bit_mask;

   assign done_now = (width_ff == 8'd0) || (row_ff >= height_ff);
   assign y_sum    = 8'(origin_y_ff) + 8'(row_ff);
   // flipped row must land in 0..SCREEN_ROWS-1
   assign y_ok_now = (9'(y_sum) <= 9'(FLIP_BASE))
                     && ((9'(FLIP_BASE) - 9'(y_sum)) < 9'(SCREEN_ROWS));
   assign x_pos    = (COL_W+1)'(origin_x_ff) + (COL_W+1)'(col_ff);
   assign pix_vis  = yok_ff && (x_pos < (COL_W+1)'(SCREEN_COLUMNS));
   assign pix_addr = AW'(32'(y_ff[6:3]) * 32'(SCREEN_COLUMNS) + 32'(x_pos));
   assign index_ok = 32'(index_ff) < 32'(DEPTH);

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in    = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in   = csr_wdata[6:0];
            CSR_ORIGIN_X:     origin_x_in = csr_wdata[6:0];
            CSR_ORIGIN_Y:     origin_y_in = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pattern_in     = pattern_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      req_type_in    = req_type_ff;
      code_in        = code_ff;
      index_in       = index_ff;
      run_pattern_in = run_pattern_ff;
      col_in         = col_ff;
      pix_in         = pix_ff;
      total_in       = total_ff;
      y_in           = y_ff;
      yok_in         = yok_ff;
      wr_pend_in     = 1'b0;
      wr_addr_in     = pix_addr;
      wr_bit_in      = y_ff[2:0];
      wr_on_in       = run_pattern_ff[~pix_ff[2:0]];
      clr_in         = clr_ff;
      read_data_in   = read_data_ff;
      done_in        = done_ff;

      if (cmd.capture) begin
         req_type_in = req_type;
         code_in     = code_byte;
         index_in    = read_index;
      end
      if (cmd.start_image) begin
         phase_in   = PHASE_IDLE;
         pattern_in = 8'd0;
         column_in  = 8'd0;
         row_in     = 7'd0;
      end
      if (cmd.set_escape) begin
         phase_in = PHASE_PATTERN;
      end
      if (cmd.set_pattern) begin
         pattern_in = code_ff;
         phase_in   = PHASE_COUNT;
      end
      if (cmd.run_load) begin
         phase_in = PHASE_IDLE;
         col_in   = COL_W'(column_ff);
         pix_in   = '0;
         y_in     = 7'(9'(FLIP_BASE) - 9'(y_sum));
         yok_in   = y_ok_now;
         if (cmd.run_from_pending) begin
            run_pattern_in = pattern_ff;
            total_in       = {code_ff, 3'b000};
         end else begin
            run_pattern_in = code_ff;
            total_in       = PIX_W'(8);
         end
      end
      if (cmd.draw) begin
         wr_pend_in = pix_vis;
         col_in     = col_ff + COL_W'(1);
         pix_in     = pix_ff + PIX_W'(1);
      end
      if (cmd.run_end) begin
         if (col_ff >= COL_W'(width_ff)) begin
            column_in = 8'd0;
            row_in    = row_ff + 7'd1;
         end else begin
            column_in = col_ff[7:0];
         end
      end
      if (cmd.clear) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.rsp_load) begin
         read_data_in = ((req_type_ff == REQ_READ) && index_ok) ? ram_rd_data : 8'd0;
         done_in      = done_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 8'd128;
         height_ff   <= 7'd64;
         origin_x_ff <= 7'd0;
         origin_y_ff <= 6'd0;
         phase_ff    <= PHASE_IDLE;
         pattern_ff  <= 8'd0;
         column_ff   <= 8'd0;
         row_ff      <= 7'd0;
         pix_ff      <= '0;
         total_ff    <= '0;
         wr_pend_ff  <= 1'b0;
         clr_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         phase_ff    <= phase_in;
         pattern_ff  <= pattern_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         pix_ff      <= pix_in;
         total_ff    <= total_in;
         wr_pend_ff  <= wr_pend_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff    <= req_type_in;
      code_ff        <= code_in;
      index_ff       <= index_in;
      run_pattern_ff <= run_pattern_in;
      col_ff         <= col_in;
      y_ff           <= y_in;
      yok_ff         <= yok_in;
      wr_addr_ff     <= wr_addr_in;
      wr_bit_ff      <= wr_bit_in;
      wr_on_ff       <= wr_on_in;
      read_data_ff   <= read_data_in;
      done_ff        <= done_in;
   end

   // pixel k is read while pixel k-1 is written back; addresses never coincide
   assign bit_mask    = 8'd1 << wr_bit_ff;
   assign ram_wr_en   = cmd.clear || wr_pend_ff;
   assign ram_wr_addr = cmd.clear ? clr_ff : wr_addr_ff;
   assign ram_wr_data = cmd.clear ? 8'd0
                      : (wr_on_ff ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask));
   assign ram_rd_en   = cmd.read_mem || (cmd.draw && pix_vis);
   assign ram_rd_addr = cmd.read_mem ? AW'(index_ff) : pix_addr;

   rbb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign stat.req_type   = req_type_ff;
   assign stat.phase      = phase_ff;
   assign stat.is_escape  = (code_ff == ESCAPE_BYTE);
   assign stat.done       = done_now;
   assign stat.run_more   = (pix_ff != total_ff);
   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));

   assign read_data  = read_data_ff;
   assign image_done = done_ff;

   `RBB_ASSERT(a_rmw_no_collide, clock, reset,
      (wr_pend_ff && ram_rd_en) |-> (wr_addr_ff != ram_rd_addr))
   `RBB_ASSERT(a_pix_bounded, clock, reset, pix_ff <= total_ff)
   `RBB_ASSERT(a_clear_no_pixel, clock, reset, cmd.clear |-> !wr_pend_ff)
endmodule
`default_nettype wire

// ===== rtl/core/rbb_ctrl.sv =====
// Blitter controller: clearing pass, request dispatch, pixel walk sequencing
// and the response handshake. Depends on rbb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rbb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbb_pkg::rbb_stat_type stat,
   output rbb_pkg::rbb_cmd_type      cmd,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready
);
   import rbb_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DISPATCH = 3'd2;
   localparam logic [2:0] S_DRAW     = 3'd3;
   localparam logic [2:0] S_FINISH   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            unique case (stat.req_type)
               REQ_START: cmd.start_image = 1'b1;
               REQ_READ:  cmd.read_mem    = 1'b1;
               REQ_BYTE: begin
                  // bytes after the last row, or while the width is zero, are ignored
                  if (!stat.done) begin
                     unique case (stat.phase)
                        PHASE_PATTERN: cmd.set_pattern = 1'b1;
                        PHASE_COUNT: begin
                           cmd.run_load         = 1'b1;
                           cmd.run_from_pending = 1'b1;
                           state_in             = S_DRAW;
                        end
                        default: begin
                           if (stat.is_escape) begin
                              cmd.set_escape = 1'b1;
                           end else begin
                              cmd.run_load = 1'b1;
                              state_in     = S_DRAW;
                           end
                        end
                     endcase
                  end
               end
               default: ;
            endcase
         end
         S_DRAW: begin
            if (stat.run_more) begin
               cmd.draw = 1'b1;
            end else begin
               cmd.run_end = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RBB_ASSERT(a_rsp_drop_needs_ready, clock, reset,
      $fell(rsp_valid_ff) |-> $past(rsp_ready))
   `RBB_ASSERT(a_one_item_in_flight, clock, reset,
      (req_valid && req_ready) |=> !req_ready)
   `RBB_ASSERT(a_rsp_not_overwritten, clock, reset,
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
endmodule
`default_nettype wire

// ===== rtl/core/rle_bitmap_blitter_unit.sv =====
// Escape-byte run-length bitmap blitter into a page-organized framebuffer.
// After reset a clearing pass zeroes all SCREEN_COLUMNS * ceil(SCREEN_ROWS/8)
// framebuffer bytes (1024 at the defaults) before the first request is
// taken; CSR writes are taken at any time. Requests are handled one at a time.
// A start, a read or a byte that only changes decoder phase passes from
// acceptance through the dispatch and finish states to the response register.
// A drawn byte walks its pixels through one framebuffer read-modify-write each,
// pipelined on the RAM's read and write ports.
// A new request is accepted while the previous response still waits.
// Depends on rbb_pkg, rbb_req_if, rbb_rsp_if, rbb_ctrl and rbb_datapath.
`timescale 1ns / 1ps
`default_nettype none
module rle_bitmap_blitter_unit #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS    = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rbb_req_if.sink         req_ch,
   rbb_rsp_if.source       rsp_ch,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import rbb_pkg::*;

   rbb_cmd_type  cmd;
   rbb_stat_type stat;

   rbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

   rbb_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_type   (req_ch.req_type),
      .code_byte  (req_ch.code_byte),
      .read_index (req_ch.read_index),
      .read_data  (rsp_ch.read_data),
      .image_done (rsp_ch.image_done)
   );
endmodule
`default_nettype wire

// ===== verif/rbb_tb_pkg.sv =====
// Shared constants for the blitter testbench: screen geometry and the unused
// request code. Depends on nothing.
`timescale 1ns / 1ps
package rbb_tb_pkg;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int SCREEN_COLS = 128;
   localparam int SCREEN_ROWS = 64;
   localparam int FB_DEPTH    = SCREEN_COLS * ((SCREEN_ROWS + 7) / 8);

endpackage

// ===== verif/rbb_checker.sv =====
// Scoreboard for the blitter: mirrors CSR writes, predicts one response per accepted
// request transaction and compares it against the response channel.
// Depends on rbb_pkg, rbb_tb_pkg, rbb_req_if and rbb_rsp_if.
`timescale 1ns / 1ps
module rbb_checker (
   input  logic       clock,
   input  logic       reset,
   rbb_req_if         req_mon,
   rbb_rsp_if         rsp_mon,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         open_count
);
   import rbb_pkg::*;
   import rbb_tb_pkg::*;

   typedef struct packed {
      logic [7:0] read_data;
      logic       image_done;
   } blit_rsp_type;

   logic [7:0] fb_img [0:FB_DEPTH-1];
   logic [1:0] dec_phase;
   logic [7:0] held_pattern;
   int         col_pos;
   logic [6:0] row_pos;
   logic       img_done;

   logic [7:0] cfg_width;
   logic [6:0] cfg_height;
   logic [6:0] cfg_ox;
   logic [5:0] cfg_oy;

   blit_rsp_type pending_rsps [$];

   function automatic void refresh_done();
      img_done = (cfg_width == 8'd0) || (row_pos >= cfg_height);
   endfunction

   function automatic void plot_pixel(int x, int y, logic on);
      int idx;
      if (x >= SCREEN_COLS || y < 0 || y >= SCREEN_ROWS) return;
      idx = (y / 8) * SCREEN_COLS + x;
      fb_img[idx][y % 8] = on;
   endfunction

   // overshoot past the width stays on the current row; the row only ends afterwards
   function automatic void draw_span(logic [7:0] pattern, int unsigned count);
      int col;
      int y;
      int unsigned r;
      int i;
      col = col_pos;
      y = FLIP_BASE - (int'(cfg_oy) + int'(row_pos));
      for (r = 0; r < count; r++) begin
         for (i = 7; i >= 0; i--) begin
            plot_pixel(int'(cfg_ox) + col, y, pattern[i]);
            col++;
         end
      end
      if (col >= int'(cfg_width)) begin
         col_pos = 0;
         row_pos = row_pos + 7'd1;
      end else begin
         col_pos = col;
      end
   endfunction

   function automatic blit_rsp_type blit_request(logic [1:0] kind, logic [7:0] code,
                                                 logic [9:0] idx);
      blit_rsp_type rsp;
      rsp.read_data = '0;
      case (kind)
         REQ_START: begin
            dec_phase    = PHASE_IDLE;
            held_pattern = '0;
            col_pos      = 0;
            row_pos      = '0;
            refresh_done();
         end
         REQ_BYTE: begin
            if (!img_done) begin
               case (dec_phase)
                  PHASE_PATTERN: begin
                     held_pattern = code;
                     dec_phase    = PHASE_COUNT;
                  end
                  PHASE_COUNT: begin
                     draw_span(held_pattern, code);
                     dec_phase = PHASE_IDLE;
                  end
                  default: begin
                     if (code == ESCAPE_BYTE) dec_phase = PHASE_PATTERN;
                     else draw_span(code, 1);
                  end
               endcase
               refresh_done();
            end
         end
         REQ_READ: begin
            if (idx < FB_DEPTH) rsp.read_data = fb_img[idx];
         end
         default: ;
      endcase
      rsp.image_done = img_done;
      return rsp;
   endfunction

   always @(posedge clock) begin
      blit_rsp_type want;
      if (reset) begin
         for (int i = 0; i < FB_DEPTH; i++) fb_img[i] = '0;
         dec_phase    = PHASE_IDLE;
         held_pattern = '0;
         col_pos      = 0;
         row_pos      = '0;
         cfg_width    = 8'd128;
         cfg_height   = 7'd64;
         cfg_ox       = '0;
         cfg_oy       = '0;
         refresh_done();
         pending_rsps.delete();
         fail_count   = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width  = csr_wdata;
               CSR_IMAGE_HEIGHT: cfg_height = csr_wdata[6:0];
               CSR_ORIGIN_X:     cfg_ox     = csr_wdata[6:0];
               CSR_ORIGIN_Y:     cfg_oy     = csr_wdata[5:0];
               default: ;
            endcase
            refresh_done();
         end
         if (req_mon.valid && req_mon.ready)
            pending_rsps.push_back(blit_request(req_mon.req_type, req_mon.code_byte,
                                                req_mon.read_index));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected response, read_data %02h image_done %0b", $time,
                        rsp_mon.read_data, rsp_mon.image_done);
               fail_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_mon.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %02h, got %02h", $time,
                           want.read_data, rsp_mon.read_data);
                  fail_count++;
               end
               if (rsp_mon.image_done !== want.image_done) begin
                  $display("%0t: image_done expected %0b, got %0b", $time,
                           want.image_done, rsp_mon.image_done);
                  fail_count++;
               end
            end
         end
      end
      open_count <= pending_rsps.size();
   end

endmodule

// ===== verif/tb.sv =====
// Top of the blitter testbench: clock, reset, request/response/CSR stimulus and the
// verdict. Depends on rbb_pkg, rbb_tb_pkg, the channel interfaces, rbb_checker, the RTL.
`timescale 1ns / 1ps
module tb;
   import rbb_pkg::*;
   import rbb_tb_pkg::*;

   localparam int ITEM_GOAL = 700;
   localparam int LONG_HOLD = 300;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   int         fail_count;
   int         open_count;

   int send_gap_max = 17;
   int recv_gap_max = 17;
   int holds_asked  = 0;
   int items_sent   = 0;
   int cur_w = 128, cur_h = 64, cur_ox = 0, cur_oy = 0;

   rbb_req_if req_ch ();
   rbb_rsp_if rsp_ch ();

   rle_bitmap_blitter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rbb_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("[rle_bitmap_blitter_unit] ERROR");
      $finish;
   end

   // response side: random stalls, plus a long hold-off whenever the stimulus asks
   initial begin
      int gap;
      int holds_done;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (holds_asked > holds_done) begin
            holds_done++;
            gap = LONG_HOLD;
         end else begin
            gap = $urandom_range(0, recv_gap_max);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                            input logic [9:0] idx);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.code_byte  <= code;
      req_ch.read_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_start();
      send_item(REQ_START, 8'($urandom), 10'($urandom));
   endtask

   task automatic send_code(input logic [7:0] code);
      send_item(REQ_BYTE, code, 10'($urandom));
   endtask

   task automatic send_read(input logic [9:0] idx);
      send_item(REQ_READ, 8'($urandom), idx);
   endtask

   // sender pause: drop valid and wait until every response is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   task automatic start_phase(input int w, input int h, input int ox, input int oy);
      drain_results();
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= 8'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= 8'(h);
      @(posedge clock);
      csr_index <= CSR_ORIGIN_X;
      csr_wdata <= 8'(ox);
      @(posedge clock);
      csr_index <= CSR_ORIGIN_Y;
      csr_wdata <= 8'(oy);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_w  = w;
      cur_h  = h;
      cur_ox = ox;
      cur_oy = oy;
   endtask

   // mostly addresses around the rows and columns the current image touches
   function automatic logic [9:0] near_image_index();
      int row;
      int y;
      int col;
      if ($urandom_range(0, 3) == 0) return 10'($urandom_range(0, FB_DEPTH - 1));
      row = $urandom_range(0, cur_h);
      y = FLIP_BASE - (cur_oy + row);
      if (y < 0) y = 0;
      if (y > SCREEN_ROWS - 1) y = SCREEN_ROWS - 1;
      col = cur_ox + $urandom_range(0, cur_w + 8);
      if (col > SCREEN_COLS - 1) col = SCREEN_COLS - 1;
      return 10'((y / 8) * SCREEN_COLS + col);
   endfunction

   task automatic send_stream(input int n);
      int k;
      int pick;
      logic [7:0] b;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            b = 8'($urandom);
            if (b == ESCAPE_BYTE) b = ~b;
            send_code(b);
         end else if (pick < 85) begin
            send_code(ESCAPE_BYTE);
            if ($urandom_range(0, 19) == 0) begin
               send_start();   // broken escape sequence
            end else begin
               send_code(($urandom_range(0, 9) == 0) ? ESCAPE_BYTE : 8'($urandom));
               send_code(($urandom_range(0, 29) == 0) ? 8'd255 : 8'($urandom_range(0, 6)));
            end
         end else if (pick < 92) begin
            send_read(near_image_index());
         end else if (pick < 97) begin
            send_item(REQ_UNUSED, 8'($urandom), 10'($urandom));
         end else begin
            send_start();
         end
      end
   endtask

   initial begin
      int phase_no;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = '0;
      req_ch.code_byte  = '0;
      req_ch.read_index = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: 128 x 64 at origin 0,0
      send_read(10'd0);
      send_read(10'h3FF);
      send_start();
      send_code(ESCAPE_BYTE);   // image row 0 flips to screen row 64: dropped
      send_code(8'hA5);
      send_code(8'd16);
      send_code(8'h81);
      send_code(ESCAPE_BYTE);   // escape in the pattern slot, zero count
      send_code(ESCAPE_BYTE);
      send_code(8'd0);
      send_code(ESCAPE_BYTE);   // long run far past the screen edge
      send_code(8'hC3);
      send_code(8'd255);
      send_item(REQ_UNUSED, 8'hFF, 10'h3FF);
      send_read(10'(7 * SCREEN_COLS));
      send_read(10'(7 * SCREEN_COLS + 8));
      send_read(10'(6 * SCREEN_COLS + 127));

      start_phase(1, 1, 127, 63);
      send_start();
      send_code(8'hFF);
      send_code(8'h00);         // ignored, image already done
      send_read(10'd127);
      start_phase(0, 64, 0, 0);
      send_start();
      send_code(8'hFF);

      phase_no = 0;
      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 7))
            0: start_phase(128, 64, 0, 0);
            1: start_phase(1, 1, 127, 63);
            2: begin
               if ($urandom_range(0, 1) == 0)
                  start_phase(0, $urandom_range(1, 64), $urandom_range(0, 127),
                              $urandom_range(0, 63));
               else
                  start_phase($urandom_range(1, 128), 0, $urandom_range(0, 127),
                              $urandom_range(0, 63));
            end
            default: start_phase($urandom_range(1, 48), $urandom_range(1, 64),
                                 $urandom_range(0, 127), $urandom_range(0, 63));
         endcase
         send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
         recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
         if (phase_no == 0 || $urandom_range(0, 7) == 0) holds_asked++;
         repeat ($urandom_range(1, 2)) begin
            send_start();
            send_stream($urandom_range(8, 40));
            if ($urandom_range(0, 3) == 0) drain_results();
            repeat ($urandom_range(4, 12)) send_read(near_image_index());
         end
         phase_no++;
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[rle_bitmap_blitter_unit] OK");
      else
         $display("[rle_bitmap_blitter_unit] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rbb_pkg.sv
rtl/core/rbb_req_if.sv
rtl/core/rbb_rsp_if.sv
rtl/core/rbb_ram.sv
rtl/core/rbb_datapath.sv
rtl/core/rbb_ctrl.sv
rtl/core/rle_bitmap_blitter_unit.sv
verif/rbb_tb_pkg.sv
verif/rbb_checker.sv
verif/tb.sv
